// ----- rtl/core/rwf_pkg.sv -----
// Shared types, constants and the mode decision function of the right-wall follower.
package rwf_pkg;

  localparam int SECTOR_WIDTH = 40;
  localparam int SCAN_LENGTH  = 120;

  localparam int IDX_W   = 7;
  localparam int RANGE_W = 16;
  localparam int SPEED_W = 10;
  localparam int TURN_W  = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [RANGE_W-1:0] NO_RANGE = 16'hFFFF;

  localparam logic [SPEED_W-1:0] SPEED_FORWARD = 10'd500;
  localparam logic [SPEED_W-1:0] SPEED_LEFT    = 10'd550;
  localparam logic [SPEED_W-1:0] SPEED_RIGHT   = 10'd650;

  localparam logic signed [TURN_W-1:0] TURN_NONE  = 13'sd0;
  localparam logic signed [TURN_W-1:0] TURN_LEFT  = 13'sd800;
  localparam logic signed [TURN_W-1:0] TURN_RIGHT = -13'sd2700;

  localparam logic [RANGE_W-1:0] TOUCH_RESET = 16'd1050;
  localparam logic [RANGE_W-1:0] NEAR_RESET  = 16'd650;

  localparam logic [CFG_IDX_W-1:0] REG_TOUCH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR  = 2'd1;

  typedef enum logic [1:0] {
    MODE_SEEK      = 2'd0,
    MODE_TURN_LEFT = 2'd1,
    MODE_FIND_WALL = 2'd2,
    MODE_FOLLOW    = 2'd3
  } nav_mode_e;

  typedef struct packed {
    nav_mode_e                  mode;
    logic [SPEED_W-1:0]         speed;
    logic signed [TURN_W-1:0]   turn;
  } cmd_t;

  typedef struct packed {
    logic r_touch;
    logic r_near;
    logic f_touch;
  } near_flags_t;

  function automatic cmd_t nav_eval(input nav_mode_e start, input near_flags_t nf);
    nav_mode_e m;
    logic      done;
    cmd_t      c;
    m    = start;
    done = 1'b0;
    c    = '{mode: MODE_TURN_LEFT, speed: SPEED_LEFT, turn: TURN_LEFT};
    for (int k = 0; k < 4; k++) begin
      if (!done) begin
        unique case (m)
          MODE_SEEK: begin
            if (!nf.r_touch && !nf.f_touch) begin
              c    = '{mode: MODE_SEEK, speed: SPEED_FORWARD, turn: TURN_NONE};
              done = 1'b1;
            end else begin
              m = nf.r_touch ? MODE_FOLLOW : MODE_TURN_LEFT;
            end
          end
          MODE_TURN_LEFT: begin
            if (nf.r_near || nf.f_touch) begin
              c    = '{mode: MODE_TURN_LEFT, speed: SPEED_LEFT, turn: TURN_LEFT};
              done = 1'b1;
            end else begin
              m = nf.r_touch ? MODE_FOLLOW : MODE_FIND_WALL;
            end
          end
          MODE_FIND_WALL: begin
            if (!nf.r_touch && !nf.f_touch) begin
              c    = '{mode: MODE_FIND_WALL, speed: SPEED_RIGHT, turn: TURN_RIGHT};
              done = 1'b1;
            end else begin
              m = nf.r_touch ? MODE_FOLLOW : MODE_TURN_LEFT;
            end
          end
          MODE_FOLLOW: begin
            if (nf.r_touch && !nf.r_near && !nf.f_touch) begin
              c    = '{mode: MODE_FOLLOW, speed: SPEED_FORWARD, turn: TURN_NONE};
              done = 1'b1;
            end else begin
              m = !nf.r_touch ? MODE_FIND_WALL : MODE_TURN_LEFT;
            end
          end
          default: begin
            m = MODE_TURN_LEFT;
          end
        endcase
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/rwf_sector_min.sv -----
// Running and latched range minima over the right and front sectors.
module rwf_sector_min
  import rwf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               sample_en_i,
  input  logic [IDX_W-1:0]   sample_index_i,
  input  logic [RANGE_W-1:0] range_mm_i,
  output logic [RANGE_W-1:0] right_min_o,
  output logic [RANGE_W-1:0] front_min_o
);

  localparam logic [IDX_W:0] RightEnd = (IDX_W+1)'(SECTOR_WIDTH);
  localparam logic [IDX_W:0] FrontEnd = (IDX_W+1)'(2 * SECTOR_WIDTH);
  localparam logic [IDX_W:0] ScanEnd  = (IDX_W+1)'(SCAN_LENGTH);
  localparam logic [IDX_W:0] LastIdx  = (IDX_W+1)'(SCAN_LENGTH - 1);

  logic [RANGE_W-1:0] right_run_q, right_run_d;
  logic [RANGE_W-1:0] front_run_q, front_run_d;
  logic [RANGE_W-1:0] right_lat_q, right_lat_d;
  logic [RANGE_W-1:0] front_lat_q, front_lat_d;
  logic [IDX_W:0]     idx_ext;
  logic [RANGE_W-1:0] right_new;
  logic [RANGE_W-1:0] front_new;

  assign idx_ext = {1'b0, sample_index_i};

  always_comb begin
    right_new = right_run_q;
    front_new = front_run_q;
    if (idx_ext < RightEnd) begin
      if (range_mm_i < right_run_q) right_new = range_mm_i;
    end else if (idx_ext < FrontEnd) begin
      if (range_mm_i < front_run_q) front_new = range_mm_i;
    end

    right_run_d = right_run_q;
    front_run_d = front_run_q;
    right_lat_d = right_lat_q;
    front_lat_d = front_lat_q;
    if (sample_en_i && (idx_ext < ScanEnd)) begin
      if (idx_ext == LastIdx) begin
        right_lat_d = right_new;
        front_lat_d = front_new;
        right_run_d = NO_RANGE;
        front_run_d = NO_RANGE;
      end else begin
        right_run_d = right_new;
        front_run_d = front_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_run_q <= NO_RANGE;
      front_run_q <= NO_RANGE;
      right_lat_q <= NO_RANGE;
      front_lat_q <= NO_RANGE;
    end else begin
      right_run_q <= right_run_d;
      front_run_q <= front_run_d;
      right_lat_q <= right_lat_d;
      front_lat_q <= front_lat_d;
    end
  end

  assign right_min_o = right_lat_q;
  assign front_min_o = front_lat_q;

endmodule

// ----- rtl/core/rwf_nav.sv -----
// Wall-following mode machine: threshold compares, mode chain and command build.
module rwf_nav
  import rwf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tick_en_i,
  input  logic [RANGE_W-1:0] right_min_i,
  input  logic [RANGE_W-1:0] front_min_i,
  input  logic [RANGE_W-1:0] touch_thr_i,
  input  logic [RANGE_W-1:0] near_thr_i,
  output cmd_t               cmd_o
);

  nav_mode_e   mode_q, mode_d;
  near_flags_t flags;
  cmd_t        cmd;

  always_comb begin
    flags.r_touch = (right_min_i <= touch_thr_i);
    flags.r_near  = (right_min_i <= near_thr_i);
    flags.f_touch = (front_min_i <= touch_thr_i);
    cmd    = nav_eval(mode_q, flags);
    mode_d = tick_en_i ? cmd.mode : mode_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SEEK;
    end else begin
      mode_q <= mode_d;
    end
  end

  assign cmd_o = cmd;

endmodule

// ----- rtl/core/right_wall_follow_controller_unit.sv -----
// Right-wall follower top level: stream ports, config registers, input and result registers.
// One beat is taken every clock cycle while s_axis_tready is high. A beat passes through the
// input register and is processed from there; a tick's command is loaded into the result
// register at the end of the cycle in which the tick is processed. Range samples produce no
// output. The result register lets new beats flow in while a command waits; input stalls
// only when a tick reaches processing while an earlier command is still held by
// m_axis_tready low. Config writes are taken every cycle and must be made while the block
// is idle.
module right_wall_follow_controller_unit
  import rwf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,  // [6:0] sample_index, [22:7] range_mm
  input  logic                 s_axis_tuser,  // [0] kind
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,  // [1:0] mode, [11:2] linear_speed, [24:12] turn_rate
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [RANGE_W-1:0]   cfg_data_i
);

  logic               stage_valid_q, stage_valid_d;
  logic               stage_kind_q;
  logic [IDX_W-1:0]   stage_idx_q;
  logic [RANGE_W-1:0] stage_range_q;
  logic               out_valid_q, out_valid_d;
  cmd_t               out_cmd_q;
  logic [RANGE_W-1:0] touch_q, near_q;
  logic               in_fire, stage_fire, tick_fire;
  logic [RANGE_W-1:0] right_min, front_min;
  cmd_t               cmd;

  assign stage_fire    = stage_valid_q && (!stage_kind_q || !out_valid_q || m_axis_tready);
  assign tick_fire     = stage_fire && stage_kind_q;
  assign s_axis_tready = !stage_valid_q || stage_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (in_fire) begin
      stage_valid_d = 1'b1;
    end else if (stage_fire) begin
      stage_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (tick_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
      touch_q       <= TOUCH_RESET;
      near_q        <= NEAR_RESET;
    end else begin
      stage_valid_q <= stage_valid_d;
      out_valid_q   <= out_valid_d;
      if (cfg_valid_i && (cfg_index_i == REG_TOUCH)) touch_q <= cfg_data_i;
      if (cfg_valid_i && (cfg_index_i == REG_NEAR))  near_q  <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stage_kind_q  <= s_axis_tuser;
      stage_idx_q   <= s_axis_tdata[IDX_W-1:0];
      stage_range_q <= s_axis_tdata[IDX_W+RANGE_W-1:IDX_W];
    end
    if (tick_fire) begin
      out_cmd_q <= cmd;
    end
  end

  rwf_sector_min u_sector_min (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_en_i    (stage_fire && !stage_kind_q),
    .sample_index_i (stage_idx_q),
    .range_mm_i     (stage_range_q),
    .right_min_o    (right_min),
    .front_min_o    (front_min)
  );

  rwf_nav u_nav (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_en_i   (tick_fire),
    .right_min_i (right_min),
    .front_min_i (front_min),
    .touch_thr_i (touch_q),
    .near_thr_i  (near_q),
    .cmd_o       (cmd)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_cmd_q.turn, out_cmd_q.speed, out_cmd_q.mode};

endmodule
